// ===== hdl/qrde_pkg.sv =====
// Shared types, constants and helper functions for the QR data bitstream encoder.
package qrde_pkg;

  localparam int unsigned STG_W = 48;
  localparam int unsigned SR_W  = 56;

  typedef enum logic [1:0] {
    MODE_SEG    = 2'd0,
    MODE_CHAR   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_PAD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_ECI   = 2'd1,
    ERR_CHAR  = 2'd2,
    ERR_OVFL  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    REG_VERSION = 3'd0,
    REG_LIMIT   = 3'd1,
    REG_FNC1    = 3'd2,
    REG_APP_EN  = 3'd3,
    REG_APP_IDX = 3'd4,
    REG_APP_TOT = 3'd5,
    REG_APP_PAR = 3'd6
  } reg_idx_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  // One command from the front: right-aligned bit string, its width, and status.
  typedef struct packed {
    logic [STG_W-1:0] val;
    logic [5:0]       w;
    logic [1:0]       err;
    logic             done;
  } cmd_t;

  typedef struct packed {
    logic [7:0] codeword;
    logic       last;
    logic       done;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] PAD_A = 8'hEC;
  localparam logic [7:0] PAD_B = 8'h11;

  function automatic logic [4:0] count_width(input logic [1:0] kind, input logic [1:0] vg);
    logic [4:0] r;
    begin
      r = 5'd8;
      case (kind)
        2'd0: r = (vg == 2'd0) ? 5'd10 : ((vg == 2'd1) ? 5'd12 : 5'd14);
        2'd1: r = (vg == 2'd0) ? 5'd9  : ((vg == 2'd1) ? 5'd11 : 5'd13);
        2'd2: r = (vg == 2'd0) ? 5'd8  : 5'd16;
        default: r = (vg == 2'd0) ? 5'd8 : ((vg == 2'd1) ? 5'd10 : 5'd12);
      endcase
      return r;
    end
  endfunction

  // Alphanumeric table lookup: bit 6 set means the code is not in the set.
  function automatic logic [6:0] alnum_map(input logic [15:0] c);
    logic [6:0] r;
    begin
      r = 7'h40;
      if (c >= 16'h30 && c <= 16'h39) r = 7'(c - 16'h30);
      else if (c >= 16'h41 && c <= 16'h5A) r = 7'(c - 16'h41 + 16'd10);
      else begin
        case (c)
          16'h20: r = 7'd36;
          16'h24: r = 7'd37;
          16'h25: r = 7'd38;
          16'h2A: r = 7'd39;
          16'h2B: r = 7'd40;
          16'h2D: r = 7'd41;
          16'h2E: r = 7'd42;
          16'h2F: r = 7'd43;
          16'h3A: r = 7'd44;
          default: r = 7'h40;
        endcase
      end
      return r;
    end
  endfunction

endpackage

// ===== hdl/qr_data_bitstream_encoder.sv =====
// Top level of the QR data bitstream encoder.
// This block turns segment, character, finish and pad items into a stream of
// 8-bit QR data codewords, most significant bit first. Items enter through a
// queue-style port (push/full) and codewords leave through another (empty/pop);
// each item yields up to six codewords, the last marked by last_of_run, and an
// item that is rejected yields exactly one codeword of zero with its error code.
// An item that completes no codeword yields no result. The front part registers
// each item and stages its bits combinationally, then passes a command through a
// four-entry queue to the back part, which emits one codeword per cycle while the
// two-entry result queue has room; it loads a new command only while idle, so it
// takes no new item before the codewords of the last are out. Configuration writes
// are always ready and should be made while the block is idle.
module qr_data_bitstream_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_segment_kind,
  input  logic [15:0] in_segment_length,
  input  logic [15:0] in_char_value,
  input  logic        in_eci_present,
  input  logic [19:0] in_eci_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_codeword,
  output logic        out_last_of_run,
  output logic        out_message_done,
  output logic [1:0]  out_error_code
);

  logic              cq_push, cq_pop;
  qrde_pkg::cmd_t    cq_wdata, cq_rdata;
  qrde_pkg::q_stat_t cq_stat;
  qrde_pkg::res_t    res;

  // The register file accepts a transfer on every cycle.
  assign cfg_ready = 1'b1;

  qrde_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_mode(in_mode),
    .in_segment_kind(in_segment_kind), .in_segment_length(in_segment_length),
    .in_char_value(in_char_value), .in_eci_present(in_eci_present),
    .in_eci_value(in_eci_value),
    .cq_push(cq_push), .cq_wdata(cq_wdata), .cq_stat(cq_stat)
  );

  qrde_cmdq u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(cq_push), .wdata(cq_wdata),
    .pop(cq_pop), .rdata(cq_rdata), .stat(cq_stat)
  );

  qrde_back u_back (
    .clk(clk), .rst_n(rst_n), .cq_rdata(cq_rdata), .cq_stat(cq_stat),
    .cq_pop(cq_pop), .out_empty(out_empty), .out_pop(out_pop), .res(res)
  );

  // Result fields come straight from the head of the result queue.
  assign out_codeword     = res.codeword;
  assign out_last_of_run  = res.last;
  assign out_message_done = res.done;
  assign out_error_code   = res.err;

endmodule

// ===== hdl/qrde_cmdq.sv =====
// Four-entry command queue between the front and back parts.
module qrde_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qrde_pkg::cmd_t  wdata,
  input  logic            pop,
  output qrde_pkg::cmd_t  rdata,
  output qrde_pkg::q_stat_t stat
);

  qrde_pkg::cmd_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign stat.full  = (cnt_r == 3'd4);
  assign stat.empty = (cnt_r == 3'd0);
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      if (push && !pop) cnt_r <= cnt_r + 3'd1;
      else if (pop && !push) cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== hdl/qrde_front.sv =====
// Front part: configuration registers, item classification and bit staging.
module qrde_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_segment_kind,
  input  logic [15:0] in_segment_length,
  input  logic [15:0] in_char_value,
  input  logic        in_eci_present,
  input  logic [19:0] in_eci_value,
  output logic        cq_push,
  output qrde_pkg::cmd_t cq_wdata,
  input  qrde_pkg::q_stat_t cq_stat
);

  logic [5:0]  ver_r;
  logic [11:0] lim_r;
  logic [1:0]  fnc1_r;
  logic        app_en_r;
  logic [3:0]  app_idx_r, app_tot_r;
  logic [7:0]  app_par_r;

  logic        hv_r;
  logic [1:0]  h_mode_r, h_kind_r;
  logic [15:0] h_len_r, h_char_r;
  logic        h_eci_on_r;
  logic [19:0] h_eci_r;

  logic [14:0] total_r, total_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] crem_r, crem_nxt;
  logic [9:0]  gbuf_r, gbuf_nxt;
  logic [1:0]  gpos_r, gpos_nxt;
  logic [1:0]  hflags_r, hflags_nxt;
  logic        ptog_r, ptog_nxt;

  logic [14:0] cap;
  logic [1:0]  vg;
  logic [4:0]  cw;
  logic        accept, consume;

  logic [47:0] v;
  logic [5:0]  w;
  logic [1:0]  err;
  logic [15:0] sum;
  logic [6:0]  amap;
  logic [15:0] kd;
  logic [12:0] code;
  logic        bad;
  logic [2:0]  pos, gsize;
  logic [9:0]  nbuf;
  logic [3:0]  kw;
  logic [12:0] kv;
  logic [2:0]  t, al;
  logic [14:0] room;

  assign cap     = {lim_r, 3'b000};
  assign vg      = (ver_r <= 6'd9) ? 2'd0 : ((ver_r <= 6'd26) ? 2'd1 : 2'd2);
  assign cw      = qrde_pkg::count_width(h_kind_r, vg);
  assign consume = hv_r && !cq_stat.full;
  assign in_full = hv_r && cq_stat.full;
  assign accept  = in_push && !in_full;
  assign cq_push = consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= 6'd1; lim_r <= 12'd19; fnc1_r <= '0; app_en_r <= 1'b0;
      app_idx_r <= '0; app_tot_r <= '0; app_par_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrde_pkg::REG_VERSION: ver_r     <= cfg_wdata[5:0];
        qrde_pkg::REG_LIMIT:   lim_r     <= cfg_wdata;
        qrde_pkg::REG_FNC1:    fnc1_r    <= cfg_wdata[1:0];
        qrde_pkg::REG_APP_EN:  app_en_r  <= cfg_wdata[0];
        qrde_pkg::REG_APP_IDX: app_idx_r <= cfg_wdata[3:0];
        qrde_pkg::REG_APP_TOT: app_tot_r <= cfg_wdata[3:0];
        qrde_pkg::REG_APP_PAR: app_par_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hv_r <= 1'b0;
    else if (accept) hv_r <= 1'b1;
    else if (consume) hv_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_mode_r <= in_mode; h_kind_r <= in_segment_kind; h_len_r <= in_segment_length;
      h_char_r <= in_char_value; h_eci_on_r <= in_eci_present; h_eci_r <= in_eci_value;
    end
  end

  always_comb begin
    v = '0; w = '0; err = qrde_pkg::ERR_OK;
    total_nxt = total_r; kind_nxt = kind_r; crem_nxt = crem_r; gbuf_nxt = gbuf_r;
    gpos_nxt = gpos_r; hflags_nxt = hflags_r; ptog_nxt = ptog_r;
    amap = '0; kd = '0; code = '0; bad = 1'b0; pos = '0; gsize = '0; nbuf = '0;
    kw = '0; kv = '0; t = '0; al = '0; room = '0;
    case (h_mode_r)
      qrde_pkg::MODE_SEG: begin
        if ((32'(h_len_r) >> cw) != 32'd0) err = qrde_pkg::ERR_OVFL;
        if (app_en_r && !hflags_r[0]) begin
          v = {28'd0, 4'd3, app_idx_r, app_tot_r, app_par_r};
          w = 6'd20;
          hflags_nxt[0] = 1'b1;
        end
        if (fnc1_r != 2'd0 && !hflags_r[1]) begin
          v = (v << 4) | ((fnc1_r == 2'd1) ? 48'd5 : 48'd9);
          w = w + 6'd4;
          hflags_nxt[1] = 1'b1;
        end
        v = (v << 4) | (48'd1 << h_kind_r);
        v = (v << cw) | 48'(h_len_r);
        w = w + 6'd4 + 6'(cw);
        kind_nxt = h_kind_r; crem_nxt = h_len_r; gbuf_nxt = '0; gpos_nxt = '0;
      end
      qrde_pkg::MODE_CHAR: begin
        if (crem_r == 16'd0) err = qrde_pkg::ERR_CHAR;
        else begin
          if (h_eci_on_r && gpos_r == 2'd0) begin
            if (h_eci_r > 20'd999999) err = qrde_pkg::ERR_ECI;
            else if (h_eci_r < 20'd128) begin
              v = {36'd0, 4'd7, h_eci_r[7:0]}; w = 6'd12;
            end else if (h_eci_r < 20'd16384) begin
              v = {28'd0, 4'd7, 2'b10, h_eci_r[13:0]}; w = 6'd20;
            end else begin
              v = {20'd0, 4'd7, 4'b1100, h_eci_r}; w = 6'd28;
            end
          end
          case (kind_r)
            2'd0: begin
              bad = !(h_char_r >= 16'h30 && h_char_r <= 16'h39);
              code = 13'(h_char_r - 16'h30);
            end
            2'd1: begin
              amap = qrde_pkg::alnum_map(h_char_r);
              bad = amap[6];
              code = 13'(amap[5:0]);
            end
            2'd2: begin
              bad = (h_char_r > 16'hFF);
              code = 13'(h_char_r[7:0]);
            end
            default: begin
              if (h_char_r >= 16'h8140 && h_char_r <= 16'h9FFC) kd = h_char_r - 16'h8140;
              else if (h_char_r >= 16'hE040 && h_char_r <= 16'hEBBF) kd = h_char_r - 16'hC140;
              else bad = 1'b1;
              code = 13'(16'(kd[15:8]) * 16'h00C0 + 16'(kd[7:0]));
            end
          endcase
          if (err == qrde_pkg::ERR_OK && bad) err = qrde_pkg::ERR_CHAR;
          gsize = (kind_r == 2'd0) ? 3'd3 : ((kind_r == 2'd1) ? 3'd2 : 3'd1);
          pos = 3'(gpos_r) + 3'd1;
          nbuf = (kind_r == 2'd0) ? 10'(14'(gbuf_r) * 14'd10 + 14'(code)) : 10'(code);
          if (pos >= gsize || crem_r == 16'd1) begin
            case (kind_r)
              2'd0: begin
                kw = (pos == 3'd3) ? 4'd10 : ((pos == 3'd2) ? 4'd7 : 4'd4);
                kv = 13'(nbuf);
              end
              2'd1: begin
                kw = (pos == 3'd2) ? 4'd11 : 4'd6;
                kv = (pos == 3'd2) ? 13'(16'(gbuf_r) * 16'd45 + 16'(code)) : code;
              end
              2'd2: begin kw = 4'd8; kv = code; end
              default: begin kw = 4'd13; kv = code; end
            endcase
            v = (v << kw) | 48'(kv & 13'((14'd1 << kw) - 14'd1));
            w = w + 6'(kw);
            pos = '0; nbuf = '0;
          end
          crem_nxt = crem_r - 16'd1; gpos_nxt = pos[1:0]; gbuf_nxt = nbuf;
        end
      end
      qrde_pkg::MODE_FINISH: begin
        if (total_r < cap) room = cap - total_r;
        t = (room > 15'd4) ? 3'd4 : room[2:0];
        al = 3'(4'd8 - 4'((total_r[2:0] + t[2:0]) & 3'd7));
        w = 6'(t) + 6'(al);
        crem_nxt = '0; gbuf_nxt = '0; gpos_nxt = '0;
      end
      default: begin
        if (total_r >= cap) err = qrde_pkg::ERR_OVFL;
        al = 3'(4'd8 - 4'(total_r[2:0]));
        v = 48'(ptog_r ? qrde_pkg::PAD_B : qrde_pkg::PAD_A);
        w = 6'(al) + 6'd8;
        ptog_nxt = !ptog_r;
      end
    endcase
    sum = 16'(total_r) + 16'(w);
    if (err == qrde_pkg::ERR_OK && sum > 16'(cap)) err = qrde_pkg::ERR_OVFL;
    total_nxt = sum[14:0];
    cq_wdata.val  = (err == qrde_pkg::ERR_OK) ? v : '0;
    cq_wdata.w    = (err == qrde_pkg::ERR_OK) ? w : '0;
    cq_wdata.err  = err;
    cq_wdata.done = (err == qrde_pkg::ERR_OK) ? (total_nxt >= cap) : (total_r >= cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0; kind_r <= '0; crem_r <= '0; gbuf_r <= '0; gpos_r <= '0;
      hflags_r <= '0; ptog_r <= 1'b0;
    end else if (consume && err == qrde_pkg::ERR_OK) begin
      total_r <= total_nxt; kind_r <= kind_nxt; crem_r <= crem_nxt; gbuf_r <= gbuf_nxt;
      gpos_r <= gpos_nxt; hflags_r <= hflags_nxt; ptog_r <= ptog_nxt;
    end
  end

endmodule

// ===== hdl/qrde_back.sv =====
// Back part: bit packer that cuts staged bits into codewords and a result queue.
module qrde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  qrde_pkg::cmd_t cq_rdata,
  input  qrde_pkg::q_stat_t cq_stat,
  output logic           cq_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output qrde_pkg::res_t res
);

  qrde_pkg::bk_state_t state_r, state_nxt;
  logic [qrde_pkg::SR_W-1:0] sr_r, sr_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;

  qrde_pkg::res_t oq_r [2];
  logic oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic oq_full, oq_push, oq_pop;
  qrde_pkg::res_t oq_wdata;

  logic [47:0] data_left;
  logic [5:0]  cnt_sum;

  assign oq_full   = (oq_cnt_r == 2'd2);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop && !out_empty;
  assign res       = oq_r[oq_rp_r];

  always_comb begin
    state_nxt = state_r; sr_nxt = sr_r; cnt_nxt = cnt_r; done_nxt = done_r;
    cq_pop = 1'b0; oq_push = 1'b0; oq_wdata = '0;
    data_left = cq_rdata.val << (6'd48 - cq_rdata.w);
    cnt_sum = cnt_r + cq_rdata.w;
    case (state_r)
      qrde_pkg::BK_IDLE: begin
        if (!cq_stat.empty && !oq_full) begin
          cq_pop = 1'b1;
          if (cq_rdata.err != qrde_pkg::ERR_OK) begin
            oq_push = 1'b1;
            oq_wdata = '{codeword: 8'd0, last: 1'b1, done: cq_rdata.done, err: cq_rdata.err};
          end else begin
            sr_nxt = sr_r | ({data_left, 8'd0} >> cnt_r);
            cnt_nxt = cnt_sum;
            done_nxt = cq_rdata.done;
            if (cnt_sum >= 6'd8) state_nxt = qrde_pkg::BK_EMIT;
          end
        end
      end
      qrde_pkg::BK_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          oq_wdata = '{codeword: sr_r[55:48], last: (cnt_r - 6'd8) < 6'd8,
                       done: done_r, err: qrde_pkg::ERR_OK};
          sr_nxt = sr_r << 8;
          cnt_nxt = cnt_r - 6'd8;
          if ((cnt_r - 6'd8) < 6'd8) state_nxt = qrde_pkg::BK_IDLE;
        end
      end
      default: state_nxt = qrde_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrde_pkg::BK_IDLE; sr_r <= '0; cnt_r <= '0; done_r <= 1'b0;
      oq_wp_r <= 1'b0; oq_rp_r <= 1'b0; oq_cnt_r <= '0;
    end else begin
      state_r <= state_nxt; sr_r <= sr_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
      if (oq_push) oq_wp_r <= !oq_wp_r;
      if (oq_pop)  oq_rp_r <= !oq_rp_r;
      if (oq_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (oq_pop && !oq_push) oq_cnt_r <= oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wp_r] <= oq_wdata;
  end

`ifndef SYNTH
  a_idle_residue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qrde_pkg::BK_IDLE |-> cnt_r < 6'd8) else $error("residue of 8 or more bits");
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'd2) else $error("result queue count out of range");
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cq_pop && cq_rdata.err != qrde_pkg::ERR_OK) |-> cq_rdata.w == 6'd0)
    else $error("error command carries bits");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qrde_pkg::BK_EMIT && !oq_full |=> cnt_r == $past(cnt_r) - 6'd8)
    else $error("emit did not consume a codeword");
`endif

endmodule
